[sv/mfd_pkg.sv]
package mfd_pkg;

	// Header layout: transaction id, protocol id, length (big-endian), unit id
	localparam int unsigned HEADER_BYTES = 7;
	localparam int unsigned HDR_IDX_W    = 3;

	typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

	localparam hdr_idx_t IDX_TID_HI = hdr_idx_t'(0);
	localparam hdr_idx_t IDX_TID_LO = hdr_idx_t'(1);
	localparam hdr_idx_t IDX_PID_HI = hdr_idx_t'(2);
	localparam hdr_idx_t IDX_PID_LO = hdr_idx_t'(3);
	localparam hdr_idx_t IDX_LEN_HI = hdr_idx_t'(4);
	localparam hdr_idx_t IDX_LEN_LO = hdr_idx_t'(5);
	localparam hdr_idx_t IDX_UNIT   = hdr_idx_t'(HEADER_BYTES - 1);

	localparam logic [15:0] LEN_NONE  = 16'd0;
	localparam logic [15:0] LEN_EMPTY = 16'd1;

endpackage

[sv/mbap_frame_deframer_core.sv]
// Output: a result shows on the output register in the cycle after its request is accepted;
//   header bytes (save a length-one frame's unit byte) and dropped body bytes produce nothing.
// Throughput: one request per cycle; the only stall comes from a full output register whose
//   request is itself stalled by the sink.
// Reset: arst_n clears the deframer to header hunting, clears the captured header fields,
//   empties the output register and sets expected_protocol to 0; output payload is not reset.
module mbap_frame_deframer_core
	import mfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        abort,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pdu_byte,
	output logic [15:0] transaction,
	output logic [7:0]  unit,
	output logic        first_byte,
	output logic        last_byte,
	output logic        empty_body
);

	// Configuration
	logic [15:0] expected_protocol_q;

	// Deframer state
	logic        in_body_q;
	hdr_idx_t    header_index_q;
	logic [15:0] hdr_transaction_q;
	logic [15:0] hdr_protocol_q;
	logic [15:0] hdr_length_q;
	logic [7:0]  hdr_unit_q;
	logic [15:0] body_remaining_q;
	logic        body_started_q;

	// Output register
	logic        out_valid_q;
	logic [7:0]  pdu_byte_q;
	logic [15:0] transaction_q;
	logic [7:0]  unit_q;
	logic        first_byte_q;
	logic        last_byte_q;
	logic        empty_body_q;

	logic        accept;
	logic        out_load;
	logic        proto_match;
	logic        hdr_done;
	logic [15:0] body_rem_dec;
	logic        body_last;

	// Result of the current request
	logic        res_valid;
	logic [7:0]  res_byte;
	logic        res_first;
	logic        res_last;
	logic        res_empty;

	// Hold input only while a finished result sits stalled in the output register;
	// otherwise that register drains and refills in the same cycle.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign out_load = !(out_valid_q && out_stall);

	assign proto_match  = (hdr_protocol_q == expected_protocol_q);
	assign hdr_done     = !in_body_q && (header_index_q == IDX_UNIT);
	assign body_rem_dec = body_remaining_q - 16'd1;
	assign body_last    = (body_rem_dec == 16'd0);

	// The length is complete by the time the unit byte arrives, so the
	// registered length decides the header-complete branch.
	always_comb begin
		res_valid = 1'b0;
		res_byte  = rx_byte;
		res_first = 1'b0;
		res_last  = 1'b0;
		res_empty = 1'b0;
		if (accept && !abort) begin
			if (in_body_q) begin
				res_valid = proto_match;
				res_first = !body_started_q;
				res_last  = body_last;
			end else if (hdr_done && hdr_length_q == LEN_EMPTY) begin
				res_valid = proto_match;
				res_byte  = 8'd0;
				res_first = 1'b1;
				res_last  = 1'b1;
				res_empty = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_protocol_q <= 16'd0;
		end else if (cfg_wr_en) begin
			expected_protocol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q         <= 1'b0;
			header_index_q    <= IDX_TID_HI;
			body_remaining_q  <= 16'd0;
			body_started_q    <= 1'b0;
			hdr_transaction_q <= 16'd0;
			hdr_protocol_q    <= 16'd0;
			hdr_length_q      <= 16'd0;
			hdr_unit_q        <= 8'd0;
		end else if (accept) begin
			if (abort) begin
				// Drop the partial frame; captured header fields stay.
				in_body_q        <= 1'b0;
				header_index_q   <= IDX_TID_HI;
				body_remaining_q <= 16'd0;
				body_started_q   <= 1'b0;
			end else if (in_body_q) begin
				body_started_q <= 1'b1;
				if (body_last) begin
					in_body_q        <= 1'b0;
					header_index_q   <= IDX_TID_HI;
					body_remaining_q <= 16'd0;
					body_started_q   <= 1'b0;
				end else begin
					body_remaining_q <= body_rem_dec;
				end
			end else begin
				unique case (header_index_q)
					IDX_TID_HI: hdr_transaction_q[15:8] <= rx_byte;
					IDX_TID_LO: hdr_transaction_q[7:0]  <= rx_byte;
					IDX_PID_HI: hdr_protocol_q[15:8]    <= rx_byte;
					IDX_PID_LO: hdr_protocol_q[7:0]     <= rx_byte;
					IDX_LEN_HI: hdr_length_q[15:8]      <= rx_byte;
					IDX_LEN_LO: hdr_length_q[7:0]       <= rx_byte;
					default:    hdr_unit_q              <= rx_byte;
				endcase
				if (hdr_done) begin
					header_index_q <= IDX_TID_HI;
					body_started_q <= 1'b0;
					if (hdr_length_q == LEN_NONE || hdr_length_q == LEN_EMPTY) begin
						in_body_q        <= 1'b0;
						body_remaining_q <= 16'd0;
					end else begin
						in_body_q        <= 1'b1;
						body_remaining_q <= hdr_length_q - 16'd1;
					end
				end else begin
					header_index_q <= header_index_q + hdr_idx_t'(1);
				end
			end
		end
	end

	// Output register: advance whenever the sink is not stalling a held result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= res_valid;
		end
	end

	// The unit byte of the header updates hdr_unit_q in the same edge, so the
	// empty-body result takes the unit straight from the request.
	always_ff @(posedge clk) begin
		if (out_load && res_valid) begin
			pdu_byte_q    <= res_byte;
			transaction_q <= hdr_transaction_q;
			unit_q        <= res_empty ? rx_byte : hdr_unit_q;
			first_byte_q  <= res_first;
			last_byte_q   <= res_last;
			empty_body_q  <= res_empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign pdu_byte    = pdu_byte_q;
	assign transaction = transaction_q;
	assign unit        = unit_q;
	assign first_byte  = first_byte_q;
	assign last_byte   = last_byte_q;
	assign empty_body  = empty_body_q;

	a_body_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (header_index_q == IDX_TID_HI && body_remaining_q != 16'd0))
		else $error("body phase with stale header index or empty count");

	a_abort_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && abort) |=> (!in_body_q && header_index_q == IDX_TID_HI && !out_valid_q))
		else $error("abort did not restart header collection");

	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_body_q) |-> (first_byte_q && last_byte_q))
		else $error("empty-body result without first and last marks");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result lost");

endmodule

[tb/mbap_frame_deframer_core_test.sv]
module mbap_frame_deframer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mfd_pkg::*;

	// One delivered body byte (or an empty-frame marker) as it leaves the block
	typedef struct packed {
		logic [7:0]  pdu;
		logic [15:0] tid;
		logic [7:0]  uid;
		logic        first;
		logic        last;
		logic        empty;
	} pdu_rec_t;

	// How a scripted request is checked
	typedef enum logic [1:0] {BY_MODEL, NO_RESULT, TYPED} chk_e;

	typedef struct packed {
		logic [7:0] b;
		logic       ab;
		chk_e       chk;
		pdu_rec_t   want;
	} row_t;

	localparam pdu_rec_t NO_REC = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'h0000;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        abort = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  pdu_byte;
	logic [15:0] transaction;
	logic [7:0]  unit;
	logic        first_byte;
	logic        last_byte;
	logic        empty_body;

	mbap_frame_deframer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.abort       (abort),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pdu_byte    (pdu_byte),
		.transaction (transaction),
		.unit        (unit),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.empty_body  (empty_body)
	);

	always #1 clk = ~clk;

	// Deframer shadow state, advanced once per accepted request
	logic        fr_in_body;
	hdr_idx_t    fr_pos;
	logic [15:0] fr_tid;
	logic [15:0] fr_pid;
	logic [15:0] fr_len;
	logic [7:0]  fr_uid;
	logic [15:0] fr_left;
	logic        fr_seen;
	logic [15:0] fr_proto;

	pdu_rec_t expected_pdus [$];

	int  errors = 0;
	int  requests_sent = 0;
	int  pdus_checked = 0;
	int  protocol_writes = 0;
	bit  quiet = 1'b0;    // no idling on either side near the end of the run
	bit  hold_req = 1'b0; // ask the sink for one long hold-off

	// Directed script, starts right after reset with expected_protocol = 0
	row_t script [0:30] = '{
		// length one: single empty-marked result at header end, all-ones transaction and unit ids
		'{8'hFF, 1'b0, BY_MODEL, NO_REC},
		'{8'hFF, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h01, 1'b0, BY_MODEL, NO_REC},
		'{8'hFF, 1'b0, TYPED, '{8'h00, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1}},
		// zero length: header thrown away, nothing delivered
		'{8'h12, 1'b0, BY_MODEL, NO_REC},
		'{8'h34, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h7E, 1'b0, NO_RESULT, NO_REC},
		// length two, all-zero ids: one body byte that is both first and last
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'h02, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, BY_MODEL, NO_REC},
		'{8'hFF, 1'b0, TYPED, '{8'hFF, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b0}},
		// wrong protocol with maximum length: body dropped, then abort mid-body
		'{8'hA5, 1'b0, BY_MODEL, NO_REC},
		'{8'h5A, 1'b0, BY_MODEL, NO_REC},
		'{8'hFF, 1'b0, BY_MODEL, NO_REC},
		'{8'hFF, 1'b0, BY_MODEL, NO_REC},
		'{8'hFF, 1'b0, BY_MODEL, NO_REC},
		'{8'hFF, 1'b0, BY_MODEL, NO_REC},
		'{8'h80, 1'b0, BY_MODEL, NO_REC},
		'{8'h00, 1'b0, NO_RESULT, NO_REC},
		'{8'hFF, 1'b1, NO_RESULT, NO_REC}
	};

	function automatic void rewind_header();
		fr_in_body = 1'b0;
		fr_pos     = IDX_TID_HI;
		fr_left    = 16'h0000;
		fr_seen    = 1'b0;
	endfunction

	// Advance the shadow deframer by one request; return 1 when it delivers a result
	function automatic bit deframe_step(input logic [7:0] b, input logic ab,
			output pdu_rec_t rec);
		logic first;
		logic last;
		logic match;
		rec = NO_REC;
		if (ab) begin
			// abort keeps the captured header fields, only the framing restarts
			rewind_header();
			return 1'b0;
		end
		match = (fr_pid == fr_proto);
		if (fr_in_body) begin
			first   = ~fr_seen;
			fr_left = fr_left - 16'd1;
			last    = (fr_left == 16'd0);
			fr_seen = 1'b1;
			rec     = '{b, fr_tid, fr_uid, first, last, 1'b0};
			if (last)
				rewind_header();
			return match;
		end
		case (fr_pos)
			IDX_TID_HI: fr_tid[15:8] = b;
			IDX_TID_LO: fr_tid[7:0]  = b;
			IDX_PID_HI: fr_pid[15:8] = b;
			IDX_PID_LO: fr_pid[7:0]  = b;
			IDX_LEN_HI: fr_len[15:8] = b;
			IDX_LEN_LO: fr_len[7:0]  = b;
			default:    fr_uid       = b;
		endcase
		fr_pos = fr_pos + hdr_idx_t'(1);
		if (int'(fr_pos) < HEADER_BYTES)
			return 1'b0;
		// header complete; the protocol match is taken from the captured fields
		match = (fr_pid == fr_proto);
		if (fr_len == LEN_NONE) begin
			rewind_header();
			return 1'b0;
		end
		if (fr_len == LEN_EMPTY) begin
			rewind_header();
			rec = '{8'h00, fr_tid, fr_uid, 1'b1, 1'b1, 1'b1};
			return match;
		end
		fr_in_body = 1'b1;
		fr_pos     = IDX_TID_HI;
		fr_left    = fr_len - 16'd1;
		fr_seen    = 1'b0;
		return 1'b0;
	endfunction

	// Offer one request, wait for its acceptance, then maybe idle. Called at a falling edge.
	task automatic push_byte(input logic [7:0] b, input logic ab, input chk_e chk,
			input pdu_rec_t want);
		pdu_rec_t rec;
		bit hit;
		rx_byte  <= b;
		abort    <= ab;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		hit = deframe_step(b, ab, rec);
		if (chk == TYPED)
			expected_pdus.push_back(want);
		else if (chk == BY_MODEL && hit)
			expected_pdus.push_back(rec);
		requests_sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	// Send one frame; cut >= 0 replaces the byte at that position by an abort and ends the frame
	task automatic send_frame(input logic [15:0] tid, input logic [15:0] pid,
			input logic [15:0] len, input logic [7:0] uid, input int cut);
		logic [7:0] hdr [0:6];
		int total;
		hdr   = '{tid[15:8], tid[7:0], pid[15:8], pid[7:0], len[15:8], len[7:0], uid};
		total = HEADER_BYTES + ((len > 16'd1) ? int'(len) - 1 : 0);
		for (int i = 0; i < total; i++) begin
			if (i == cut) begin
				push_byte(8'($urandom), 1'b1, BY_MODEL, NO_REC);
				return;
			end
			push_byte((i < HEADER_BYTES) ? hdr[i] : 8'($urandom), 1'b0, BY_MODEL, NO_REC);
		end
	endtask

	// Mostly well-formed frames with random content; some noise, aborts and foreign protocols
	task automatic run_frames(input int n);
		int stop_at;
		int pick;
		int len_pick;
		logic [15:0] pid;
		logic [15:0] len;
		int cut;
		stop_at = requests_sent + n;
		while (requests_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// line noise, then resynchronize with an abort
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, BY_MODEL, NO_REC);
				push_byte(8'($urandom), 1'b1, BY_MODEL, NO_REC);
			end else if (pick < 7) begin
				push_byte(8'($urandom), 1'b1, BY_MODEL, NO_REC);
			end else begin
				pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : fr_proto;
				len_pick = $urandom_range(0, 99);
				cut = -1;
				if (len_pick < 8)
					len = LEN_NONE;
				else if (len_pick < 18)
					len = LEN_EMPTY;
				else if (len_pick < 93)
					len = 16'($urandom_range(2, 16));
				else if (len_pick < 98)
					len = 16'($urandom_range(17, 200));
				else begin
					// huge frames are always cut short to keep the run brief
					len = 16'($urandom_range(16'h0100, 16'hFFFF));
					cut = $urandom_range(7, 40);
				end
				if (cut < 0 && $urandom_range(0, 11) == 0)
					cut = $urandom_range(0, HEADER_BYTES - 1 + ((len > 16'd1) ? int'(len) - 1 : 0));
				send_frame(16'($urandom), pid, len, 8'($urandom), cut);
			end
		end
	endtask

	// Hold the input until every pending result has left, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_pdus.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_protocol(input logic [15:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		fr_proto = value;
		protocol_writes++;
	endtask

	function automatic void compare(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
			errors++;
		end
	endfunction

	// Sink: random hold-off bursts, one long hold-off on request, none near the end
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (60) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Check each accepted result against the oldest pending expectation
	always @(posedge clk) begin
		pdu_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			pdus_checked++;
			if (expected_pdus.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got pdu %h tid %h unit %h",
					$time, pdu_byte, transaction, unit);
				errors++;
			end else begin
				want = expected_pdus.pop_front();
				// the data byte is a don't-care on an empty-body marker
				if (!want.empty)
					compare("pdu_byte", 16'(want.pdu), 16'(pdu_byte));
				compare("transaction", want.tid, transaction);
				compare("unit", 16'(want.uid), 16'(unit));
				compare("first_byte", 16'(want.first), 16'(first_byte));
				compare("last_byte", 16'(want.last), 16'(last_byte));
				compare("empty_body", 16'(want.empty), 16'(empty_body));
			end
		end
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		fr_tid   = 16'h0000;
		fr_pid   = 16'h0000;
		fr_len   = 16'h0000;
		fr_uid   = 8'h00;
		fr_proto = 16'h0000;
		rewind_header();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed script against the reset value of the protocol register
		foreach (script[i])
			push_byte(script[i].b, script[i].ab, script[i].chk, script[i].want);

		set_protocol(16'hFFFF);
		run_frames(100);
		// long sink hold-off while a long matching frame keeps arriving
		hold_req = 1'b1;
		send_frame(16'($urandom), fr_proto, 16'd41, 8'($urandom), -1);
		run_frames(120);
		// pause the source until everything is out, then carry on
		drain();
		run_frames(50);

		set_protocol(16'($urandom_range(1, 16'hFFFE)));
		run_frames(200);

		set_protocol(16'h0000);
		run_frames(120);
		quiet = 1'b1;
		run_frames(120);
		drain();
		repeat (8) @(posedge clk);

		$display("%0d requests sent under %0d protocol settings, %0d results checked",
			requests_sent, protocol_writes + 1, pdus_checked);
		$display("covered empty, zero-length, foreign-protocol and aborted frames plus stalls");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
